/* rtl/quoted_literal_scanner_unit_defines.svh */
// ---------------------------------------------------------------------------
// Quoted literal scanner - assertion macros
// Shared concurrent assertion forms, clocked on aclk, held off during reset.
// ---------------------------------------------------------------------------
`ifndef QUOTED_LITERAL_SCANNER_UNIT_DEFINES_SVH
`define QUOTED_LITERAL_SCANNER_UNIT_DEFINES_SVH

// same-cycle implication
`define QLS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define QLS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/qls_pkg.sv */
// ---------------------------------------------------------------------------
// Quoted literal scanner - package
// Word types, character codes, event codes and the escape map.
// ---------------------------------------------------------------------------
package qls_pkg;

    localparam int BUF_BYTES_DEF = 1024;
    localparam int LIMIT_W       = 11;
    localparam int POS_OUT_W     = 10;
    localparam int CNT_W         = 16;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_W    = 2;
    localparam int FIFO_LVL_W    = 3;

    localparam logic       ACT_BEGIN    = 1'b0;
    localparam logic       ACT_CHAR     = 1'b1;
    localparam logic [1:0] KIND_COMMENT = 2'd0;
    localparam logic [1:0] KIND_CHAR    = 2'd1;
    localparam logic [1:0] KIND_STRING  = 2'd2;
    localparam logic [1:0] KIND_SPECIAL = 2'd3;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BQUOTE = 8'h60;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [1:0] DIGIT_RUN_MAX = 2'd2;

    typedef enum logic [1:0] {
        EV_STORED    = 2'd0,
        EV_DONE      = 2'd1,
        EV_UNTERM    = 2'd2,
        EV_UNTERM_AR = 2'd3
    } event_t;

    typedef struct packed {
        logic               action;
        logic [1:0]         kind;
        logic [LIMIT_W-1:0] limit;
        logic [7:0]         char_in;
    } in_item_t;

    typedef struct packed {
        event_t               event_res;
        logic [POS_OUT_W-1:0] position;
        logic [7:0]           byte_value;
        logic                 overflow;
        logic [CNT_W-1:0]     char_count;
        logic                 last;
    } result_t;

    typedef struct packed {
        result_t    r0;
        result_t    r1;
        logic [1:0] n;
    } res_pair_t;

    typedef struct packed {
        logic [FIFO_LVL_W-1:0] level;
    } fifo_stat_t;

    typedef struct packed {
        logic       known;
        logic [7:0] value;
    } esc_map_t;

    function automatic esc_map_t map_escape(input logic [7:0] c);
        esc_map_t m;
        m.known = 1'b1;
        unique case (c)
            8'h74:   m.value = 8'h09;
            8'h6E:   m.value = 8'h0A;
            8'h72:   m.value = 8'h0D;
            8'h62:   m.value = 8'h08;
            8'h66:   m.value = 8'h0C;
            default: begin
                m.known = 1'b0;
                m.value = c;
            end
        endcase
        return m;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

/* rtl/qls_core.sv */
// ---------------------------------------------------------------------------
// Quoted literal scanner - scan core
// Scan state and the per-character decode; yields up to two result words.
// ---------------------------------------------------------------------------
module qls_core import qls_pkg::*; #(
    parameter int BUF_BYTES = BUF_BYTES_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      fire,
    input  in_item_t  item,
    output res_pair_t res
);

    localparam int LimInMax = (1 << LIMIT_W) - 1;
    localparam int LimMax   = (BUF_BYTES < LimInMax) ? BUF_BYTES : LimInMax;
    localparam int PosW     = $clog2(LimMax + 1);
    localparam logic [LIMIT_W:0] LimMaxV = (LIMIT_W + 1)'(LimMax);
    localparam logic [CNT_W-1:0] CntMax  = '1;

    typedef enum logic [1:0] {
        M_IDLE,
        M_COMMENT,
        M_CON,
        M_ARRAY
    } mode_t;

    mode_t             mode_reg,   mode_next;
    logic [1:0]        dk_reg,     dk_next;
    logic [PosW-1:0]   lim_reg,    lim_next;
    logic [PosW-1:0]   wpos_reg,   wpos_next;
    logic [CNT_W-1:0]  lcnt_reg,   lcnt_next;
    logic              first_reg,  first_next;
    logic              esc_reg,    esc_next;
    logic [1:0]        drun_reg,   drun_next;
    logic [CNT_W-1:0]  bd_reg,     bd_next;
    logic              iq_reg,     iq_next;
    logic              star_reg,   star_next;

    logic              ovf0, ovf1;
    logic [PosW-1:0]   p0, p1, w1, w2;
    logic [7:0]        c, delim;
    logic [LIMIT_W:0]  lim_sat;
    esc_map_t          em;
    result_t           st0, st1, term;

    always_comb begin
        c     = item.char_in;
        em    = map_escape(c);
        ovf0  = wpos_reg >= lim_reg;
        p0    = ovf0 ? '0 : wpos_reg;
        w1    = p0 + 1'b1;
        ovf1  = w1 >= lim_reg;
        p1    = ovf1 ? '0 : w1;
        w2    = p1 + 1'b1;
        delim = (dk_reg == KIND_CHAR) ? CH_SQUOTE :
                (dk_reg == KIND_STRING) ? CH_DQUOTE : CH_BQUOTE;
        lim_sat = ({1'b0, item.limit} > LimMaxV) ? LimMaxV : {1'b0, item.limit};

        // store templates: first slot at p0, second at p1
        st0 = '{event_res: EV_STORED, position: POS_OUT_W'(p0), byte_value: c,
                overflow: ovf0, char_count: '0, last: 1'b1};
        st1 = '{event_res: EV_STORED, position: POS_OUT_W'(p1), byte_value: c,
                overflow: ovf1, char_count: '0, last: 1'b1};
        term = '{event_res: EV_DONE, position: POS_OUT_W'(p0), byte_value: '0,
                 overflow: ovf0, char_count: lcnt_reg, last: 1'b1};

        mode_next  = mode_reg;
        dk_next    = dk_reg;
        lim_next   = lim_reg;
        wpos_next  = wpos_reg;
        lcnt_next  = lcnt_reg;
        first_next = first_reg;
        esc_next   = esc_reg;
        drun_next  = drun_reg;
        bd_next    = bd_reg;
        iq_next    = iq_reg;
        star_next  = star_reg;
        res        = '0;

        if (item.action == ACT_BEGIN) begin
            wpos_next  = '0;
            lcnt_next  = '0;
            first_next = 1'b1;
            esc_next   = 1'b0;
            drun_next  = '0;
            bd_next    = '0;
            iq_next    = 1'b0;
            star_next  = 1'b0;
            dk_next    = item.kind;
            if (item.kind == KIND_COMMENT) begin
                mode_next = M_COMMENT;
            end else begin
                mode_next = M_CON;
                lim_next  = (item.kind == KIND_CHAR) ? PosW'(1) : PosW'(lim_sat);
            end
        end else if (mode_reg == M_IDLE) begin
            res.n = 2'd0;
        end else if (mode_reg == M_COMMENT) begin
            if (c == CH_NUL || (c == CH_SLASH && star_reg)) begin
                res.n  = 2'd1;
                res.r0 = '{event_res: (c == CH_NUL) ? EV_UNTERM : EV_DONE,
                           position: '0, byte_value: '0, overflow: 1'b0,
                           char_count: '0, last: 1'b1};
                mode_next = M_IDLE;
            end else begin
                star_next = (c == CH_STAR);
            end
        end else if (esc_reg) begin
            esc_next = 1'b0;
            if (c != CH_LF) begin
                if (mode_reg == M_CON) begin
                    if (lcnt_reg != CntMax) lcnt_next = lcnt_reg + 1'b1;
                    first_next = 1'b0;
                end
                if (is_digit(c)) begin
                    res.n     = 2'd1;
                    res.r0    = st0;
                    wpos_next = w1;
                    drun_next = 2'd1;
                end else if (c != CH_NUL) begin
                    if (!em.known && mode_reg == M_ARRAY) begin
                        // unknown escape inside an array keeps its backslash
                        res.n             = 2'd2;
                        res.r0            = st0;
                        res.r0.byte_value = CH_BSLASH;
                        res.r0.last       = 1'b0;
                        res.r1            = st1;
                        res.r1.byte_value = em.value;
                        wpos_next         = w2;
                    end else begin
                        res.n             = 2'd1;
                        res.r0            = st0;
                        res.r0.byte_value = em.value;
                        wpos_next         = w1;
                    end
                end
            end
        end else if (drun_reg != 2'd0 && is_digit(c)) begin
            res.n     = 2'd1;
            res.r0    = st0;
            wpos_next = w1;
            drun_next = (drun_reg >= DIGIT_RUN_MAX) ? 2'd0 : drun_reg + 2'd1;
        end else begin
            drun_next = 2'd0;
            if (mode_reg == M_ARRAY) begin
                if (c == CH_LBRACE && !iq_reg && bd_reg != CntMax) begin
                    bd_next = bd_reg + 1'b1;
                end else if (c == CH_RBRACE && !iq_reg && bd_reg != '0) begin
                    bd_next = bd_reg - 1'b1;
                end
                if (c == CH_NUL || c == CH_LF) begin
                    res.n                = 2'd1;
                    res.r0               = term;
                    res.r0.event_res     = EV_UNTERM_AR;
                    res.r0.char_count    = CNT_W'(p0);
                    lcnt_next            = CNT_W'(p0);
                    wpos_next            = p0;
                    mode_next            = M_CON;
                    first_next           = 1'b0;
                end else if (c == CH_BSLASH) begin
                    esc_next = 1'b1;
                end else begin
                    if (c == CH_DQUOTE) iq_next = ~iq_reg;
                    res.n     = 2'd1;
                    res.r0    = st0;
                    wpos_next = w1;
                    if (bd_next == '0) begin
                        mode_next  = M_CON;
                        first_next = 1'b0;
                        lcnt_next  = CNT_W'(w1);
                    end
                end
            end else begin
                if (c == delim) begin
                    res.n     = 2'd1;
                    res.r0    = term;
                    wpos_next = p0;
                    mode_next = M_IDLE;
                end else if (c == CH_NUL || c == CH_LF) begin
                    res.n            = 2'd1;
                    res.r0           = term;
                    res.r0.event_res = EV_UNTERM;
                    wpos_next        = p0;
                    mode_next        = M_IDLE;
                end else if (c == CH_BSLASH) begin
                    esc_next = 1'b1;
                end else if (c == CH_LBRACE && first_reg && dk_reg == KIND_STRING) begin
                    res.n     = 2'd1;
                    res.r0    = st0;
                    wpos_next = w1;
                    mode_next = M_ARRAY;
                    bd_next   = CNT_W'(1);
                    iq_next   = 1'b0;
                end else begin
                    res.n     = 2'd1;
                    res.r0    = st0;
                    wpos_next = w1;
                    if (lcnt_reg != CntMax) lcnt_next = lcnt_reg + 1'b1;
                    first_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= M_IDLE;
            dk_reg    <= '0;
            lim_reg   <= PosW'(1);
            wpos_reg  <= '0;
            lcnt_reg  <= '0;
            first_reg <= 1'b1;
            esc_reg   <= 1'b0;
            drun_reg  <= '0;
            bd_reg    <= '0;
            iq_reg    <= 1'b0;
            star_reg  <= 1'b0;
        end else if (fire) begin
            mode_reg  <= mode_next;
            dk_reg    <= dk_next;
            lim_reg   <= lim_next;
            wpos_reg  <= wpos_next;
            lcnt_reg  <= lcnt_next;
            first_reg <= first_next;
            esc_reg   <= esc_next;
            drun_reg  <= drun_next;
            bd_reg    <= bd_next;
            iq_reg    <= iq_next;
            star_reg  <= star_next;
        end
    end

endmodule

/* rtl/qls_fifo.sv */
// ---------------------------------------------------------------------------
// Quoted literal scanner - result queue
// Small register queue taking up to two result words a cycle, one out.
// ---------------------------------------------------------------------------
module qls_fifo import qls_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  res_pair_t  res,
    input  logic       pop,
    output result_t    head,
    output fifo_stat_t stat
);

    result_t                mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  rd_reg,  rd_next;
    logic [FIFO_PTR_W-1:0]  wr_reg,  wr_next;
    logic [FIFO_LVL_W-1:0]  lvl_reg, lvl_next;
    logic [1:0]             n_push;
    logic [FIFO_PTR_W-1:0]  wr_b;

    always_comb begin
        n_push   = push ? res.n : 2'd0;
        wr_b     = wr_reg + 1'b1;
        wr_next  = wr_reg + FIFO_PTR_W'(n_push);
        rd_next  = rd_reg + FIFO_PTR_W'(pop);
        lvl_next = lvl_reg + FIFO_LVL_W'(n_push) - FIFO_LVL_W'(pop);
        head     = mem_reg[rd_reg];
        stat     = '{level: lvl_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_reg  <= '0;
            wr_reg  <= '0;
            lvl_reg <= '0;
        end else begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            lvl_reg <= lvl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (n_push != 2'd0) mem_reg[wr_reg] <= res.r0;
        if (n_push == 2'd2) mem_reg[wr_b]   <= res.r1;
    end

endmodule

/* rtl/quoted_literal_scanner_unit.sv */
// ---------------------------------------------------------------------------
// Quoted literal scanner
// Scans comments, char, string and special constants one character a word.
// Registered path: in_item_reg, then the result queue. One input word per
// cycle while the queue has room; an array escape that keeps its backslash
// yields two result words, which drain at one per cycle while m_tready is
// high. The four-entry result queue sets how far the output may stall
// before s_tready drops. Reset: synchronous on aresetn low, scanner idle.
// ---------------------------------------------------------------------------
`include "quoted_literal_scanner_unit_defines.svh"

module quoted_literal_scanner_unit import qls_pkg::*; #(
    parameter int BUF_BYTES = BUF_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // limit[10:0], char_in[18:11], zero pad
    input  logic [2:0]  s_tuser,   // action[0], kind[2:1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // position[9:0], byte_value[17:10],
                                   // overflow[18], char_count[34:19], zero pad
    output logic [1:0]  m_tuser,   // event_res[1:0]
    output logic        m_tlast
);

    logic       in_valid_reg;
    in_item_t   in_item_reg;
    logic       fire;
    logic       pop;
    res_pair_t  res;
    result_t    head;
    fifo_stat_t stat;

    assign fire     = in_valid_reg && (stat.level <= FIFO_LVL_W'(FIFO_DEPTH - 2));
    assign s_tready = aresetn && (!in_valid_reg || fire);
    assign m_tvalid = stat.level != '0;
    assign pop      = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= '{action: s_tuser[0], kind: s_tuser[2:1],
                             limit: s_tdata[10:0], char_in: s_tdata[18:11]};
        end
    end

    qls_core #(
        .BUF_BYTES (BUF_BYTES)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_item_reg),
        .res     (res)
    );

    qls_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (fire),
        .res     (res),
        .pop     (pop),
        .head    (head),
        .stat    (stat)
    );

    assign m_tdata = {5'd0, head.char_count, head.overflow, head.byte_value, head.position};
    assign m_tuser = head.event_res;
    assign m_tlast = head.last;

    `QLS_ASSERT_SAME(a_level_bound, 1'b1, stat.level <= FIFO_LVL_W'(FIFO_DEPTH), "queue overrun")
    `QLS_ASSERT_NEXT(a_item_held, in_valid_reg && !fire, in_valid_reg, "input word lost")
    `QLS_ASSERT_SAME(a_pair_last, fire && res.n == 2'd2, !res.r0.last && res.r1.last, "bad last mark")

endmodule
